// ----- rtl/ndef_id_pin_extractor_assert.svh -----
// Assertion macros used by the checker of the NDEF id/pin extractor.
// Depends on nothing; included by the checker file.
`ifndef NDEF_ID_PIN_EXTRACTOR_ASSERT_SVH
`define NDEF_ID_PIN_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define NIP_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ndef_id_pin_extractor: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define NIP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ndef_id_pin_extractor: assertion failed");

// Next-cycle implication that is checked through reset as well.
`define NIP_ASSERT_NEXT_ANY(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ndef_id_pin_extractor: assertion failed");

`endif

// ----- rtl/nip_pkg.sv -----
// Types and constants of the NDEF id/pin extractor.
// No dependencies; nip_atol, nip_parser, the top level and the testbench import this package.
package nip_pkg;

  // Width of the extracted decimal values.
  localparam int VAL_W = 31;

  // Protocol constants.
  localparam logic [7:0] TLV_NDEF  = 8'h03;
  localparam logic [7:0] SR_MASK   = 8'h10;
  localparam logic [7:0] TYPE_TEXT = 8'h54;
  localparam logic [7:0] LANG_MASK = 8'h3F;
  localparam int         TEXT_CAP  = 48;
  localparam logic [2:0] MAX_RECORDS = 3'd4;
  localparam logic [2:0] ID_RECORD   = 3'd3;
  localparam logic [2:0] PIN_RECORD  = 3'd4;
  localparam logic [VAL_W-1:0] SAT31 = {VAL_W{1'b1}};

  // Characters seen by the text-to-number converter.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_TLVLEN,
    PH_HDR,
    PH_TLEN,
    PH_PLEN,
    PH_TYPE,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  // Number converter status.
  typedef struct packed {
    logic sign;
    logic started;
    logic stopped;
  } num_flags_t;

  // One input transaction.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       read_fail;
    logic       last_byte;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic             parse_ok;
    logic [VAL_W-1:0] card_id;
    logic [VAL_W-1:0] card_pin;
    logic             id_valid;
  } out_item_t;

endpackage

// ----- rtl/nip_stream_if.sv -----
// Valid/ready stream interface used for the byte input and the result output.
// The payload type is a parameter; no other dependencies.
interface nip_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/nip_atol.sv -----
// Combinational step of the decimal text converter: one character per call.
// Depends on nip_pkg.
module nip_atol (
  input  logic [7:0]                acc_byte,
  input  logic [nip_pkg::VAL_W-1:0] acc,
  input  nip_pkg::num_flags_t       flags,
  output logic [nip_pkg::VAL_W-1:0] acc_next,
  output nip_pkg::num_flags_t       flags_next
);
  import nip_pkg::*;

  logic        is_digit;
  logic        is_space;
  logic [34:0] mul10;

  assign is_digit = (acc_byte >= CH_ZERO) && (acc_byte <= CH_NINE);
  assign is_space = (acc_byte == CH_SPACE) || ((acc_byte >= CH_TAB) && (acc_byte <= CH_CR));

  // Multiply by ten as two shifts; the low nibble of a digit is its value.
  assign mul10 = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + 35'(acc_byte[3:0]);

  // Skip leading blanks, take one sign, then digits until anything else.
  always_comb begin
    acc_next   = acc;
    flags_next = flags;
    if (!flags.stopped) begin
      if (acc_byte == CH_NUL) begin
        flags_next.stopped = 1'b1;
      end else if (!flags.started && is_space) begin
        flags_next = flags;
      end else if (!flags.started && ((acc_byte == CH_PLUS) || (acc_byte == CH_MINUS))) begin
        flags_next.started = 1'b1;
        flags_next.sign    = (acc_byte == CH_MINUS);
      end else if (!is_digit) begin
        flags_next.stopped = 1'b1;
      end else begin
        flags_next.started = 1'b1;
        acc_next = (mul10 > 35'(SAT31)) ? SAT31 : mul10[VAL_W-1:0];
      end
    end
  end

endmodule

// ----- rtl/nip_parser.sv -----
// Parse state and per-byte next-state logic of the NDEF id/pin extractor.
// Depends on nip_pkg and nip_atol.
module nip_parser #(
  parameter int MEM_BYTES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  nip_pkg::in_item_t  item,
  output nip_pkg::out_item_t res
);
  import nip_pkg::*;

  localparam int PW = $clog2(MEM_BYTES + 1);
  localparam int SW = ((PW > 8) ? PW : 8) + 2;
  localparam logic [PW-1:0] MEM_LIMIT = PW'(MEM_BYTES);
  localparam logic [PW-1:0] LAST_POS  = PW'(MEM_BYTES - 1);

  // State registers.
  logic [PW-1:0]    byte_index, byte_index_next;
  phase_t           phase, phase_next;
  logic [PW-1:0]    message_end, message_end_next;
  logic [2:0]       record_number, record_number_next;
  logic [7:0]       type_length, type_length_next;
  logic [7:0]       payload_length, payload_length_next;
  logic [7:0]       field_offset, field_offset_next;
  logic [7:0]       record_type, record_type_next;
  logic [5:0]       language_length, language_length_next;
  logic [5:0]       text_count, text_count_next;
  logic [VAL_W-1:0] number_acc, number_acc_next;
  num_flags_t       number_flags, number_flags_next;
  logic [VAL_W-1:0] id_value, id_value_next;
  logic [VAL_W-1:0] pin_value, pin_value_next;
  logic             error_flag, error_flag_next;

  // Helpers.
  logic             in_range;
  logic             is_final;
  logic             take;
  logic             fail;
  logic             finish;
  logic [SW-1:0]    pos_w;
  logic [SW-1:0]    end_w;
  logic [SW-1:0]    tlv_end;
  logic [PW-1:0]    tlv_end_cap;
  logic             hdr_over;
  logic             rec_over;
  logic             next_pos_done;
  logic [7:0]       fo_inc;
  logic             text_window;
  logic [VAL_W-1:0] acc_fed;
  num_flags_t       flags_fed;
  logic [VAL_W-1:0] rec_value;
  logic             ok;

  assign in_range = byte_index < MEM_LIMIT;
  assign is_final = item.last_byte || (byte_index == LAST_POS);
  assign take     = in_range && !(error_flag || item.read_fail);

  // Position arithmetic, wide enough for position plus two length bytes.
  assign pos_w         = SW'(byte_index);
  assign end_w         = SW'(message_end);
  assign tlv_end       = pos_w + SW'(1) + SW'(item.data_byte);
  assign tlv_end_cap   = (tlv_end > SW'(MEM_BYTES)) ? MEM_LIMIT : tlv_end[PW-1:0];
  assign hdr_over      = (pos_w + SW'(3)) > end_w;
  assign rec_over      = (pos_w + SW'(1) + SW'(type_length) + SW'(item.data_byte)) > end_w;
  assign next_pos_done = (pos_w + SW'(1)) >= end_w;
  assign fo_inc        = field_offset + 8'd1;
  assign text_window   = (field_offset >= (8'(language_length) + 8'd1))
                         && (text_count < 6'(TEXT_CAP - 1));

  nip_atol u_atol (
    .acc_byte   (item.data_byte),
    .acc        (number_acc),
    .flags      (number_flags),
    .acc_next   (acc_fed),
    .flags_next (flags_fed)
  );

  // Next state for one accepted byte.
  always_comb begin
    byte_index_next      = in_range ? PW'(byte_index + PW'(1)) : byte_index;
    phase_next           = phase;
    message_end_next     = message_end;
    record_number_next   = record_number;
    type_length_next     = type_length;
    payload_length_next  = payload_length;
    field_offset_next    = field_offset;
    record_type_next     = record_type;
    language_length_next = language_length;
    text_count_next      = text_count;
    number_acc_next      = number_acc;
    number_flags_next    = number_flags;
    id_value_next        = id_value;
    pin_value_next       = pin_value;
    fail                 = 1'b0;
    finish               = 1'b0;

    if (take) begin
      unique case (phase)
        PH_SEARCH: begin
          if (item.data_byte == TLV_NDEF) begin
            phase_next = PH_TLVLEN;
          end
        end
        PH_TLVLEN: begin
          if (is_final) begin
            fail = 1'b1;
          end else begin
            message_end_next = tlv_end_cap;
            phase_next = ((pos_w + SW'(1)) >= SW'(tlv_end_cap)) ? PH_DONE : PH_HDR;
          end
        end
        PH_HDR: begin
          if (((item.data_byte & SR_MASK) == 8'd0) || hdr_over) begin
            fail = 1'b1;
          end else begin
            phase_next = PH_TLEN;
          end
        end
        PH_TLEN: begin
          type_length_next = item.data_byte;
          phase_next = PH_PLEN;
        end
        PH_PLEN: begin
          payload_length_next = item.data_byte;
          if (rec_over) begin
            fail = 1'b1;
          end else begin
            record_number_next   = 3'(record_number + 3'd1);
            record_type_next     = 8'd0;
            field_offset_next    = 8'd0;
            language_length_next = 6'd0;
            text_count_next      = 6'd0;
            number_acc_next      = '0;
            number_flags_next    = '0;
            if (type_length != 8'd0) begin
              phase_next = PH_TYPE;
            end else if (item.data_byte != 8'd0) begin
              phase_next = PH_PAYLOAD;
            end else begin
              finish = 1'b1;
            end
          end
        end
        PH_TYPE: begin
          if (field_offset == 8'd0) begin
            record_type_next = item.data_byte;
          end
          field_offset_next = fo_inc;
          if (fo_inc >= type_length) begin
            field_offset_next = 8'd0;
            if (payload_length != 8'd0) begin
              phase_next = PH_PAYLOAD;
            end else begin
              finish = 1'b1;
            end
          end
        end
        PH_PAYLOAD: begin
          if (field_offset == 8'd0) begin
            language_length_next = 6'(item.data_byte & LANG_MASK);
          end else if (text_window) begin
            number_acc_next   = acc_fed;
            number_flags_next = flags_fed;
            text_count_next   = text_count + 6'd1;
          end
          field_offset_next = fo_inc;
          if (fo_inc >= payload_length) begin
            finish = 1'b1;
          end
        end
        PH_DONE: begin
          phase_next = PH_DONE;
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase
    end

    // End of a record: store a text value, then decide whether more follow.
    rec_value = number_flags_next.sign ? '0 : number_acc_next;
    if (finish) begin
      if ((record_type_next == TYPE_TEXT) && (payload_length_next != 8'd0)) begin
        if (record_number_next == ID_RECORD) begin
          id_value_next = rec_value;
        end else if (record_number_next == PIN_RECORD) begin
          pin_value_next = rec_value;
        end
      end
      phase_next = ((record_number_next >= MAX_RECORDS) || next_pos_done) ? PH_DONE : PH_HDR;
    end

    if (fail) begin
      phase_next = PH_DONE;
    end
    error_flag_next = error_flag || item.read_fail || fail;
  end

  // Result of the image, taken from the state after the last byte.
  always_comb begin
    ok           = !error_flag_next && ((phase_next == PH_HDR) || (phase_next == PH_DONE));
    res.parse_ok = ok;
    res.card_id  = ok ? id_value_next : '0;
    res.card_pin = ok ? pin_value_next : '0;
    res.id_valid = ok && (id_value_next != '0);
  end

  // State update; the last byte of an image returns everything to reset.
  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      byte_index      <= '0;
      phase           <= PH_SEARCH;
      message_end     <= '0;
      record_number   <= '0;
      type_length     <= '0;
      payload_length  <= '0;
      field_offset    <= '0;
      record_type     <= '0;
      language_length <= '0;
      text_count      <= '0;
      number_acc      <= '0;
      number_flags    <= '0;
      id_value        <= '0;
      pin_value       <= '0;
      error_flag      <= 1'b0;
    end else if (step) begin
      byte_index      <= byte_index_next;
      phase           <= phase_next;
      message_end     <= message_end_next;
      record_number   <= record_number_next;
      type_length     <= type_length_next;
      payload_length  <= payload_length_next;
      field_offset    <= field_offset_next;
      record_type     <= record_type_next;
      language_length <= language_length_next;
      text_count      <= text_count_next;
      number_acc      <= number_acc_next;
      number_flags    <= number_flags_next;
      id_value        <= id_value_next;
      pin_value       <= pin_value_next;
      error_flag      <= error_flag_next;
    end
  end

endmodule

// ----- rtl/ndef_id_pin_extractor.sv -----
// NDEF id/pin extractor: one tag memory byte per transaction, one result per image.
// Throughput is one byte per cycle while the input is not stalled; the parse state updates once per byte.
// A last byte is held in the input register, then its result is registered in the result register.
// Input stalls only while a finished result waits and the next last byte is held.
// Synchronous active-high reset clears the parse state and the valid bits of both stage registers.
// Depends on nip_pkg, nip_stream_if and nip_parser.
module ndef_id_pin_extractor #(
  parameter int MEM_BYTES = 64
) (
  input  logic                clk,
  input  logic                rst,
  nip_stream_if.sink          bytes,
  nip_stream_if.source        result
);
  import nip_pkg::*;

  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t res;
  logic      out_free;
  logic      fire;

  // A byte is processed unless it closes an image and the result slot is full and not being read.
  assign out_free    = !out_valid_q || result.ready;
  assign fire        = in_valid_q && (!in_q.last_byte || out_free);
  assign bytes.ready = !in_valid_q || fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (bytes.ready) begin
      in_valid_q <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      in_q <= bytes.data;
    end
  end

  nip_parser #(
    .MEM_BYTES (MEM_BYTES)
  ) u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (fire),
    .item (in_q),
    .res  (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (fire && in_q.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (result.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_q.last_byte) begin
      out_q <= res;
    end
  end

  assign result.valid = out_valid_q;
  assign result.data  = out_q;

endmodule

// ----- rtl/nip_checker.sv -----
// Port-level checks of the NDEF id/pin extractor, bound to the top level.
// Depends on nip_pkg and ndef_id_pin_extractor_assert.svh.
`include "ndef_id_pin_extractor_assert.svh"

module nip_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input nip_pkg::out_item_t out_item
);

  // Reset empties the result slot.
  `NIP_ASSERT_NEXT_ANY(a_reset_clears, clk, rst, !out_valid)

  // A waiting result transaction is held unchanged.
  `NIP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_item))

  // With the result slot empty, nothing can block the input.
  `NIP_ASSERT_SAME(a_in_free, clk, rst, !out_valid, in_ready)

  // The id flag follows parse status and a nonzero id.
  `NIP_ASSERT_SAME(a_id_valid, clk, rst, out_valid, out_item.id_valid == (out_item.parse_ok && (out_item.card_id != '0)))

  // A failed parse reports no numbers.
  `NIP_ASSERT_SAME(a_fail_zero, clk, rst, out_valid && !out_item.parse_ok, (out_item.card_id == '0) && (out_item.card_pin == '0))

endmodule

bind ndef_id_pin_extractor nip_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (bytes.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_item  (result.data)
);

// ----- sim/tb_ndef_id_pin_extractor.sv -----
// Self-checking regression for the NDEF id/pin extractor: streams tag memory images
// through the byte channel and checks every result against a cycle-free parser model.
// Depends on nip_pkg, nip_stream_if and the ndef_id_pin_extractor RTL.
module tb_ndef_id_pin_extractor;
  import nip_pkg::*;

  localparam int MEM_BYTES = 64;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_CYCLES = 8;

  typedef bit [7:0] byte_q_t[$];

  // Parser model with its own state, plus the queue of results it predicts.
  class id_pin_scoreboard;
    bit [6:0]       byte_pos;
    phase_t         phase;
    bit [6:0]       msg_end;
    bit [2:0]       rec_num;
    bit [7:0]       type_len;
    bit [7:0]       payload_len;
    bit [7:0]       field_pos;
    bit [7:0]       rec_type;
    bit [5:0]       lang_len;
    bit [5:0]       text_len;
    bit [31:0]      acc;
    num_flags_t     flags;
    bit [VAL_W-1:0] id_val;
    bit [VAL_W-1:0] pin_val;
    bit             failed;
    out_item_t      expected_results[$];
    int images;
    int parsed_ok;
    int valid_ids;
    int results_checked;
    int mismatches;

    function new();
      clear();
    endfunction

    // Return to the state of a fresh image.
    function void clear();
      byte_pos = '0;
      phase = PH_SEARCH;
      msg_end = '0;
      rec_num = '0;
      type_len = '0;
      payload_len = '0;
      field_pos = '0;
      rec_type = '0;
      lang_len = '0;
      text_len = '0;
      acc = '0;
      flags = '0;
      id_val = '0;
      pin_val = '0;
      failed = 1'b0;
    endfunction

    // Text to number, one character at a time, in the manner of atol.
    function void convert_char(bit [7:0] b);
      bit digit;
      longint unsigned v;
      digit = (b >= CH_ZERO && b <= CH_NINE);
      if (flags.stopped) return;
      if (b == CH_NUL) begin
        flags.stopped = 1'b1;
        return;
      end
      if (!flags.started) begin
        if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) return;
        if (b == CH_PLUS || b == CH_MINUS) begin
          flags.started = 1'b1;
          if (b == CH_MINUS) flags.sign = 1'b1;
          return;
        end
        if (!digit) begin
          flags.stopped = 1'b1;
          return;
        end
        flags.started = 1'b1;
      end
      if (!digit) begin
        flags.stopped = 1'b1;
        return;
      end
      v = longint'(acc) * 10 + longint'(b - CH_ZERO);
      acc = (v > SAT31) ? {1'b0, SAT31} : v[31:0];
    endfunction

    // Store the value of a text record and move on to the next header or stop.
    function void close_record(int next_pos);
      bit [VAL_W-1:0] val;
      if (rec_type == TYPE_TEXT && payload_len >= 1) begin
        val = flags.sign ? '0 : acc[VAL_W-1:0];
        if (rec_num == ID_RECORD) id_val = val;
        else if (rec_num == PIN_RECORD) pin_val = val;
      end
      if (rec_num >= MAX_RECORDS || next_pos >= msg_end) phase = PH_DONE;
      else phase = PH_HDR;
    endfunction

    function void abort_parse();
      failed = 1'b1;
      phase = PH_DONE;
    endfunction

    // One byte of the image at position pos through the parse phases.
    function void parse_byte(bit [7:0] b, int pos, bit at_end);
      int e;
      case (phase)
        PH_SEARCH: begin
          if (b == TLV_NDEF) phase = PH_TLVLEN;
        end
        PH_TLVLEN: begin
          if (at_end) begin
            abort_parse();
          end else begin
            e = pos + 1 + int'(b);
            if (e > MEM_BYTES) e = MEM_BYTES;
            msg_end = e[6:0];
            phase = (pos + 1 >= e) ? PH_DONE : PH_HDR;
          end
        end
        PH_HDR: begin
          if ((b & SR_MASK) == 0 || pos + 3 > int'(msg_end)) abort_parse();
          else phase = PH_TLEN;
        end
        PH_TLEN: begin
          type_len = b;
          phase = PH_PLEN;
        end
        PH_PLEN: begin
          payload_len = b;
          if (pos + 1 + int'(type_len) + int'(payload_len) > int'(msg_end)) begin
            abort_parse();
          end else begin
            rec_num++;
            rec_type = '0;
            field_pos = '0;
            lang_len = '0;
            text_len = '0;
            acc = '0;
            flags = '0;
            if (type_len > 0) phase = PH_TYPE;
            else if (payload_len > 0) phase = PH_PAYLOAD;
            else close_record(pos + 1);
          end
        end
        PH_TYPE: begin
          if (field_pos == 0) rec_type = b;
          field_pos++;
          if (field_pos >= type_len) begin
            field_pos = '0;
            if (payload_len > 0) phase = PH_PAYLOAD;
            else close_record(pos + 1);
          end
        end
        PH_PAYLOAD: begin
          if (field_pos == 0) begin
            lang_len = b[5:0] & LANG_MASK[5:0];
          end else if (int'(field_pos) >= 1 + int'(lang_len) && text_len < TEXT_CAP - 1) begin
            convert_char(b);
            text_len++;
          end
          field_pos++;
          if (field_pos >= payload_len) close_record(pos + 1);
        end
        default: ;
      endcase
    endfunction

    // Note an accepted byte; the last byte of an image yields an expected result.
    function void note_byte(in_item_t it);
      out_item_t res;
      bit ok;
      if (it.read_fail) failed = 1'b1;
      if (byte_pos < MEM_BYTES) begin
        if (!failed) parse_byte(it.data_byte, byte_pos, it.last_byte || byte_pos == MEM_BYTES - 1);
        byte_pos++;
      end
      if (!it.last_byte) return;
      ok = !failed && (phase == PH_HDR || phase == PH_DONE);
      res.parse_ok = ok;
      res.card_id = ok ? id_val : '0;
      res.card_pin = ok ? pin_val : '0;
      res.id_valid = ok && res.card_id != 0;
      expected_results.push_back(res);
      images++;
      if (res.parse_ok) parsed_ok++;
      if (res.id_valid) valid_ids++;
      clear();
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    // Check an accepted result against the oldest prediction.
    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got ok=%0d id=%0d pin=%0d valid=%0d",
                 $time, got.parse_ok, got.card_id, got.card_pin, got.id_valid);
        return;
      end
      want = expected_results.pop_front();
      compare_field("parse_ok", want.parse_ok, got.parse_ok);
      compare_field("card_id", want.card_id, got.card_id);
      compare_field("card_pin", want.card_pin, got.card_pin);
      compare_field("id_valid", want.id_valid, got.id_valid);
      results_checked++;
    endfunction
  endclass

  logic clk;
  logic rst;
  int   bytes_sent;
  int   stall_cycles;

  id_pin_scoreboard sb = new();

  nip_stream_if #(.T(in_item_t))  byte_ch ();
  nip_stream_if #(.T(out_item_t)) result_ch ();

  ndef_id_pin_extractor #(
    .MEM_BYTES(MEM_BYTES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .bytes(byte_ch),
    .result(result_ch)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic bit [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Text field: optional whitespace and sign, digits, sometimes a stray tail.
  function automatic void append_text(ref byte_q_t pl);
    int r;
    int ws;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      repeat ($urandom_range(44, 48)) pl.push_back(CH_SPACE);
    end else begin
      repeat ($urandom_range(0, 2)) begin
        ws = $urandom_range(0, 5);
        pl.push_back(ws == 5 ? CH_SPACE : CH_TAB + 8'(ws));
      end
    end
    r = $urandom_range(0, 7);
    if (r == 0) pl.push_back(CH_MINUS);
    else if (r == 1) pl.push_back(CH_PLUS);
    r = $urandom_range(0, 9);
    repeat (r == 0 ? 0 : (r == 1 ? $urandom_range(10, 12) : $urandom_range(1, 8)))
      pl.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    r = $urandom_range(0, 5);
    if (r == 0) begin
      pl.push_back(CH_NUL);
      pl.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end else if (r == 1) begin
      pl.push_back(rand_byte());
    end else if (r == 2) begin
      pl.push_back(8'h78);
    end
  endfunction

  // One short record; records three and four are mostly text records.
  function automatic void append_record(ref byte_q_t msg, input int n);
    bit [7:0] hdr;
    byte_q_t  ty;
    byte_q_t  pl;
    int       r;
    int       lang;
    hdr = rand_byte() | SR_MASK;
    if ($urandom_range(0, 29) == 0) hdr = hdr & ~SR_MASK;
    r = $urandom_range(0, 19);
    if ((n == ID_RECORD || n == PIN_RECORD) ? r < 18 : r < 3) begin
      ty.push_back(TYPE_TEXT);
      if (r == 0) ty.push_back(rand_byte());
      if (r != 1) begin
        if ($urandom_range(0, 15) == 0) begin
          pl.push_back(rand_byte());
        end else begin
          lang = $urandom_range(0, 3);
          pl.push_back({2'($urandom_range(0, 3)), 6'(lang)});
          repeat (lang) pl.push_back(8'h61 + 8'($urandom_range(0, 25)));
        end
        append_text(pl);
      end
    end else begin
      repeat ($urandom_range(0, 2)) ty.push_back(rand_byte());
      repeat ($urandom_range(0, 4)) pl.push_back(rand_byte());
    end
    msg.push_back(hdr);
    msg.push_back(8'(ty.size()));
    msg.push_back(8'(pl.size()));
    msg = {msg, ty, pl};
  endfunction

  // Build one memory image: mostly well-formed messages, the rest noise or damaged.
  function automatic void build_image(ref byte_q_t img, output int fail_at);
    byte_q_t msg;
    int kind;
    int r;
    int nrec;
    int len;
    bit [7:0] b;
    fail_at = -1;
    img.delete();
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 24)) img.push_back(rand_byte());
      if ($urandom_range(0, 3) == 0) fail_at = $urandom_range(0, img.size() - 1);
      return;
    end
    r = $urandom_range(0, 9);
    nrec = (r < 3) ? r + 1 : (r == 9 ? 5 : 4);
    for (int n = 1; n <= nrec; n++) append_record(msg, n);
    repeat ($urandom_range(0, 3)) begin
      b = rand_byte();
      img.push_back(b == TLV_NDEF ? CH_NUL : b);
    end
    // Message length: usually exact, sometimes long, short or maximal.
    r = $urandom_range(0, 9);
    len = msg.size();
    if (r == 7) len = len + $urandom_range(1, 8);
    else if (r == 8) len = (len > 5) ? len - $urandom_range(1, 5) : 0;
    else if (r == 9) len = 255;
    img.push_back(TLV_NDEF);
    img.push_back(8'(len));
    img = {img, msg};
    img.push_back(8'hFE);
    repeat ($urandom_range(0, 3)) img.push_back(rand_byte());
    if (kind < 18) begin
      len = $urandom_range(MEM_BYTES, MEM_BYTES + 16);
      while (img.size() < len) img.push_back(rand_byte());
    end else if (kind < 28) begin
      len = $urandom_range(1, img.size());
      while (img.size() > len) void'(img.pop_back());
    end else if (kind < 36) begin
      img[$urandom_range(0, img.size() - 1)] = rand_byte();
    end else if (kind < 44) begin
      fail_at = $urandom_range(0, img.size() - 1);
    end
  endfunction

  // Offer the bytes of one image, each held until the block takes it.
  task automatic send_image(input byte_q_t img, input int fail_at);
    in_item_t it;
    bit burst;
    int gap;
    burst = ($urandom_range(0, 3) == 0);
    foreach (img[i]) begin
      it.data_byte = img[i];
      it.read_fail = (i == fail_at);
      it.last_byte = (i == img.size() - 1);
      gap = burst ? 0 : idle_gap();
      if (gap > 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      byte_ch.valid <= 1'b1;
      byte_ch.data <= it;
      do @(posedge clk); while (!byte_ch.ready);
      bytes_sent++;
    end
  endtask

  // Stop offering and wait until every predicted result has been checked.
  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_results.size() != 0);
  endtask

  task automatic send_directed(input byte_q_t img, input int fail_at);
    send_image(img, fail_at);
  endtask

  // Record every transaction on both channels and count cycles without one.
  always @(posedge clk) begin
    if (!rst) begin
      if (byte_ch.valid && byte_ch.ready) sb.note_byte(byte_ch.data);
      if (result_ch.valid && result_ch.ready) sb.check_result(result_ch.data);
      if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  // Result receiver: random ready pattern with one long hold-off.
  initial begin : result_sink
    bit held;
    int gap;
    held = 1'b0;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!held && sb.results_checked >= 20) begin
        held = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(0, 7) == 0 ? $urandom_range(40, 150) : $urandom_range(1, 4))
          @(posedge clk);
        gap = idle_gap();
        if (gap > 0) begin
          result_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  initial begin : watchdog
    stall_cycles = 0;
    do @(posedge clk); while (stall_cycles < STALL_LIMIT);
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("ndef_id_pin_extractor regression: fail");
    $finish;
  end

  initial begin : stimulus
    byte_q_t img;
    int fail_at;
    bytes_sent = 0;
    rst <= 1'b1;
    byte_ch.valid <= 1'b0;
    byte_ch.data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed images: no TLV with extreme bytes, TLV or its length at the very end,
    // empty message, read failure, missing SR bit, record with empty type.
    send_directed('{8'hFF, 8'h00}, -1);
    send_directed('{TLV_NDEF, 8'h07}, -1);
    send_directed('{TLV_NDEF}, -1);
    send_directed('{TLV_NDEF, 8'h00, 8'hFE}, -1);
    send_directed('{8'h00, TLV_NDEF, 8'h03, 8'h10, 8'h00, 8'h00}, 1);
    send_directed('{TLV_NDEF, 8'h03, 8'h00, 8'h00, 8'h00}, -1);
    send_directed('{TLV_NDEF, 8'h03, 8'hD0, 8'h00, 8'h00}, -1);
    wait_drained();

    // Random images until enough bytes and results have gone through.
    while (bytes_sent < 1000 || sb.images < 40) begin
      build_image(img, fail_at);
      send_image(img, fail_at);
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d tag images in %0d bytes: %0d parsed cleanly, %0d with a valid id.",
             sb.images, bytes_sent, sb.parsed_ok, sb.valid_ids);
    $display("Checked %0d results, %0d field mismatches.", sb.results_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0)
      $display("ndef_id_pin_extractor regression: pass");
    else
      $display("ndef_id_pin_extractor regression: fail");
    $finish;
  end

endmodule

// ----- ndef_id_pin_extractor.f -----
+incdir+rtl
rtl/nip_pkg.sv
rtl/nip_stream_if.sv
rtl/nip_atol.sv
rtl/nip_parser.sv
rtl/ndef_id_pin_extractor.sv
rtl/nip_checker.sv
sim/tb_ndef_id_pin_extractor.sv
